// ----- design/sbbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbbd_pkg
// Shared types, constants and width tables for the two-lane selector
// bit-packing block decoder.
// ----------------------------------------------------------------------------
package sbbd_pkg;

    localparam int LANE_W   = 32;
    localparam int SEL_W    = 8;
    localparam int PAY_W    = 2 * LANE_W;
    localparam int FW_W     = 6;   // field width 1..32
    localparam int CNT_W    = 5;   // fields per lane minus one, 0..31
    localparam int SEL_COUNT = 10;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } sbbd_state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } sbbd_cmd_t;

    typedef struct packed {
        logic sel_ok;
        logic out_free;
        logic last_field;
    } sbbd_status_t;

    function automatic logic [FW_W-1:0] field_width(input logic [3:0] sel);
        logic [FW_W-1:0] w;
        unique case (sel)
            4'd0:    w = FW_W'(1);
            4'd1:    w = FW_W'(2);
            4'd2:    w = FW_W'(3);
            4'd3:    w = FW_W'(4);
            4'd4:    w = FW_W'(5);
            4'd5:    w = FW_W'(6);
            4'd6:    w = FW_W'(8);
            4'd7:    w = FW_W'(10);
            4'd8:    w = FW_W'(16);
            default: w = FW_W'(32);
        endcase
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] field_last_idx(input logic [3:0] sel);
        logic [CNT_W-1:0] c;
        unique case (sel)
            4'd0:    c = CNT_W'(31);
            4'd1:    c = CNT_W'(15);
            4'd2:    c = CNT_W'(9);
            4'd3:    c = CNT_W'(7);
            4'd4:    c = CNT_W'(5);
            4'd5:    c = CNT_W'(4);
            4'd6:    c = CNT_W'(3);
            4'd7:    c = CNT_W'(2);
            4'd8:    c = CNT_W'(1);
            default: c = CNT_W'(0);
        endcase
        return c;
    endfunction

    function automatic logic [LANE_W-1:0] field_mask(input logic [FW_W-1:0] w);
        logic [FW_W-1:0] sh;
        sh = FW_W'(LANE_W) - w;
        return {LANE_W{1'b1}} >> sh;
    endfunction

endpackage

// ----- design/selector_bitpack_block_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selector_bitpack_block_decoder_unit
// Two-lane selector bit-packing block decoder, top level.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat is one packed block, a
// selector byte, a 64-bit payload of two 32-bit lanes and a final_block flag.
// Output channel (out_valid / out_stall): one beat per decoded field, with
// the field of the low lane, the same field of the high lane, last_of_block
// on the final field and end_of_stream on the final field of a final block.
// Selectors 0..9 give 32,16,10,8,6,5,4,3,2 or 1 beats; any other selector
// is taken and gives no beat.
// Blocks are decoded one at a time: a block with n fields occupies the unit
// until its last field is emitted, one field per cycle through the output
// register unless stalled. The first field is emitted from the run state.
// A stalled receiver holds the output beat and pauses the decoder; the
// next block is taken once the last field sits in the output register.
// Reset clears the controller and the output valid; no beat is pending.
// ----------------------------------------------------------------------------
module selector_bitpack_block_decoder_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sbbd_pkg::SEL_W-1:0]  selector,
    input  logic [sbbd_pkg::PAY_W-1:0]  payload,
    input  logic                        final_block,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sbbd_pkg::LANE_W-1:0] low_value,
    output logic [sbbd_pkg::LANE_W-1:0] high_value,
    output logic                        last_of_block,
    output logic                        end_of_stream
);
    import sbbd_pkg::*;

    sbbd_cmd_t    cmd;
    sbbd_status_t status;

    sbbd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    sbbd_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .selector      (selector),
        .payload       (payload),
        .final_block   (final_block),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .low_value     (low_value),
        .high_value    (high_value),
        .last_of_block (last_of_block),
        .end_of_stream (end_of_stream)
    );

endmodule

// ----- design/sbbd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbbd_ctrl
// Controller: takes one block at a time and paces the field beats out
// through the datapath output register.
// ----------------------------------------------------------------------------
module sbbd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  sbbd_pkg::sbbd_status_t status,
    output sbbd_pkg::sbbd_cmd_t    cmd
);
    import sbbd_pkg::*;

    sbbd_state_t state_reg;
    sbbd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.sel_ok)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_field)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_run_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> in_stall)
        else $error("input taken while a block is in progress");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == ST_IDLE) && !cmd.emit)
        else $error("load outside idle");

    a_emit_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (state_reg == ST_RUN) && status.out_free)
        else $error("emit without a free output register");

endmodule

// ----- design/sbbd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbbd_datapath
// Lane shift registers, field counter and output register; one field of
// each lane is masked off and the lanes shifted down on every emit.
// ----------------------------------------------------------------------------
module sbbd_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sbbd_pkg::SEL_W-1:0]         selector,
    input  logic [sbbd_pkg::PAY_W-1:0]         payload,
    input  logic                               final_block,
    input  sbbd_pkg::sbbd_cmd_t                cmd,
    output sbbd_pkg::sbbd_status_t             status,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [sbbd_pkg::LANE_W-1:0]        low_value,
    output logic [sbbd_pkg::LANE_W-1:0]        high_value,
    output logic                               last_of_block,
    output logic                               end_of_stream
);
    import sbbd_pkg::*;

    logic [LANE_W-1:0] low_reg;
    logic [LANE_W-1:0] high_reg;
    logic [FW_W-1:0]   width_reg;
    logic [CNT_W-1:0]  remain_reg;
    logic              final_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [LANE_W-1:0] out_low_reg;
    logic [LANE_W-1:0] out_high_reg;
    logic              out_last_reg;
    logic              out_eos_reg;

    logic [LANE_W-1:0] mask;

    assign mask = field_mask(width_reg);

    assign status.sel_ok     = (selector < SEL_W'(SEL_COUNT));
    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.last_field = (remain_reg == '0);

    // block registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            low_reg    <= payload[LANE_W-1:0];
            high_reg   <= payload[PAY_W-1:LANE_W];
            width_reg  <= field_width(selector[3:0]);
            remain_reg <= field_last_idx(selector[3:0]);
            final_reg  <= final_block;
        end
        else if (cmd.emit)
        begin
            low_reg    <= low_reg >> width_reg;
            high_reg   <= high_reg >> width_reg;
            remain_reg <= remain_reg - CNT_W'(1);
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_low_reg  <= low_reg & mask;
            out_high_reg <= high_reg & mask;
            out_last_reg <= status.last_field;
            out_eos_reg  <= status.last_field && final_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign low_value     = out_low_reg;
    assign high_value    = out_high_reg;
    assign last_of_block = out_last_reg;
    assign end_of_stream = out_eos_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && out_stall))
        else $error("output beat overwritten while stalled");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && status.last_field |=> out_valid_reg && out_last_reg)
        else $error("final field of block not marked");

    a_eos_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_eos_reg |-> out_last_reg)
        else $error("end of stream without end of block");

endmodule
